// ===== rtl/shm_pkg.sv =====
// Package with the item types, round constants and SHA-256 helper functions.
`timescale 1ns / 1ps
package shm_pkg;

  // One input item: a message byte with its valid bit and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  // One result item: a digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sha256_message_hasher.sv =====
// Top level of the SHA-256 message hasher: input queue and hashing core.
// The core takes byte items only while idle; each filled 64-byte block runs 64 rounds
// on one shared round unit and then the chaining add.
// A message end pads one byte per cycle, runs one or two compressions, then
// gives eight digest items, one per cycle while the output side is ready.
// Reset (rst_ni low, asynchronous) empties the queue and loads the initial hash value.
`timescale 1ns / 1ps
module sha256_message_hasher #(
  parameter int unsigned QueueDepth = shm_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shm_pkg::out_item_t out_data_o
);

  logic              q_valid, q_ready;
  shm_pkg::in_item_t q_data;

  shm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  shm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_data_i   (q_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // The last flag marks exactly the eighth word.
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // Once a non-final word is taken, the next one is already in the output register.
  a_words_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_word) |=>
      (out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("digest words do not follow each other");

  // The core takes no queued item while a non-final digest word is on the output.
  a_no_pop_mid_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_word) |-> !q_ready)
    else $error("core accepted an item during digest output");
`endif

endmodule

// ===== rtl/shm_queue.sv =====
// Front part: accepts items, drops empty ones and queues the rest for the core.
`timescale 1ns / 1ps
module shm_queue #(
  parameter int unsigned Depth = shm_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shm_pkg::in_item_t  in_data_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output shm_pkg::in_item_t  q_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  shm_pkg::in_item_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop, keep;

  // An item with neither a byte nor an end flag is taken and discarded.
  assign keep       = in_data_i.byte_valid | in_data_i.end_of_message;
  assign in_ready_o = (count_q != CntW'(Depth));
  assign push       = in_valid_i & in_ready_o & keep;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// ===== rtl/shm_core.sv =====
// Back part: block buffer, padding, the 64-round compression and digest output.
`timescale 1ns / 1ps
module shm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  shm_pkg::in_item_t  q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shm_pkg::out_item_t out_data_o
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_UPD, S_OUT} state_e;
  typedef enum logic [1:0] {P_ONE, P_ZERO, P_LEN} pad_e;

  state_e             state_q;
  pad_e               pad_kind_q, pad_kind_d;
  logic [511:0]       buf_q;
  logic [5:0]         fill_q, fill_d;
  logic [60:0]        len_q;
  logic [31:0]        chain_q [8];
  logic [31:0]        var_q [8];
  logic [31:0]        var_d [8];
  logic [5:0]         rnd_q;
  logic [2:0]         len_idx_q, out_idx_q;
  logic               pend_q, pad_done_q;
  logic               out_valid_q;
  shm_pkg::out_item_t out_q;

  logic [63:0]        bit_len;
  logic [7:0]         pad_byte;
  logic [31:0]        new_word, t1, t2;
  logic               pop, out_load;

  assign q_ready_o   = (state_q == S_IDLE);
  assign pop         = q_valid_i & q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_OUT) & (~out_valid_q | out_ready_i);
  assign fill_d      = fill_q + 6'd1;

  // Padding byte: the marker, zero fill, then the bit length most significant first.
  assign bit_len = {len_q, 3'b000};
  always_comb begin
    unique case (pad_kind_q)
      P_ONE:   pad_byte = shm_pkg::PadMarker;
      P_ZERO:  pad_byte = 8'h00;
      P_LEN:   pad_byte = 8'(bit_len >> (6'd56 - {len_idx_q, 3'b000}));
      default: pad_byte = 8'h00;
    endcase
    if (pad_kind_q == P_LEN) begin
      pad_kind_d = P_LEN;
    end else if (fill_d == shm_pkg::LenOffset) begin
      pad_kind_d = P_LEN;
    end else begin
      pad_kind_d = P_ZERO;
    end
  end

  // One round: the schedule window advances one word and a..h rotate.
  always_comb begin
    new_word = buf_q[511:480] + shm_pkg::small_sigma0(buf_q[479:448]) +
               buf_q[223:192] + shm_pkg::small_sigma1(buf_q[63:32]);
    t1 = var_q[7] + shm_pkg::big_sigma1(var_q[4]) +
         ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) +
         shm_pkg::RoundK[rnd_q] + buf_q[511:480];
    t2 = shm_pkg::big_sigma0(var_q[0]) +
         ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
    var_d[0] = t1 + t2;
    var_d[1] = var_q[0];
    var_d[2] = var_q[1];
    var_d[3] = var_q[2];
    var_d[4] = var_q[3] + t1;
    var_d[5] = var_q[4];
    var_d[6] = var_q[5];
    var_d[7] = var_q[6];
  end

  // Buffer and round variables hold payload only.
  always_ff @(posedge clk_i) begin
    if (pop && q_data_i.byte_valid) begin
      buf_q <= {buf_q[503:0], q_data_i.data_byte};
    end else if (state_q == S_PAD) begin
      buf_q <= {buf_q[503:0], pad_byte};
    end else if (state_q == S_ROUND) begin
      buf_q <= {buf_q[479:0], new_word};
    end
    if (state_q == S_ROUND) begin
      var_q <= var_d;
    end else begin
      var_q <= chain_q;
    end
  end

  // Sequencer with the chaining value and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pad_kind_q  <= P_ONE;
      fill_q      <= '0;
      len_q       <= '0;
      chain_q     <= shm_pkg::InitHash;
      rnd_q       <= '0;
      len_idx_q   <= '0;
      out_idx_q   <= '0;
      pend_q      <= 1'b0;
      pad_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            pend_q     <= q_data_i.end_of_message;
            pad_kind_q <= P_ONE;
            len_idx_q  <= '0;
            rnd_q      <= '0;
            if (q_data_i.byte_valid) begin
              fill_q <= fill_d;
              len_q  <= len_q + 61'd1;
            end
            if (q_data_i.byte_valid && fill_q == 6'd63) begin
              state_q <= S_ROUND;
            end else if (q_data_i.end_of_message) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill_q     <= fill_d;
          pad_kind_q <= pad_kind_d;
          rnd_q      <= '0;
          if (pad_kind_q == P_LEN) begin
            len_idx_q <= len_idx_q + 3'd1;
            if (len_idx_q == 3'd7) begin
              pad_done_q <= 1'b1;
            end
          end
          if (fill_q == 6'd63) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + var_q[i];
          end
          out_idx_q <= '0;
          if (pend_q && pad_done_q) begin
            state_q <= S_OUT;
          end else if (pend_q) begin
            state_q <= S_PAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q       <= 1'b1;
            out_q.digest_word <= chain_q[out_idx_q];
            out_q.word_index  <= out_idx_q;
            out_q.last_word   <= (out_idx_q == 3'd7);
            out_idx_q         <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              chain_q    <= shm_pkg::InitHash;
              len_q      <= '0;
              fill_q     <= '0;
              pend_q     <= 1'b0;
              pad_done_q <= 1'b0;
              state_q    <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
